@@ sv/plar_pkg.sv @@
// ----------------------------------------------------------------------------
// plar_pkg: shared types and constants
// Word layout, operation codes and sizes used by the polyline resampler.
// ----------------------------------------------------------------------------
package plar_pkg;

  localparam int MAX_PER_SEGMENT = 64;
  localparam int CNT_W           = $clog2(MAX_PER_SEGMENT + 1);
  localparam int COORD_W         = 32;
  localparam int RAD_W           = 31;
  localparam int DLT_W           = COORD_W + 1;
  localparam int LEN_W           = DLT_W;
  localparam int SQ_W            = 2 * DLT_W;
  localparam int RR_W            = 2 * RAD_W;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_AW         = $clog2(FIFO_DEPTH);

  localparam logic [RAD_W-1:0] SPACING_RESET = RAD_W'(65536);

  typedef enum logic {
    OP_BEGIN = 1'b0,
    OP_POINT = 1'b1
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
    logic        [RAD_W-1:0]    radius;
  } item_t;

endpackage

@@ sv/plar_front.sv @@
// ----------------------------------------------------------------------------
// plar_front: input stage
// Registers each incoming word, decodes its kind and hands it to the queue.
// ----------------------------------------------------------------------------
module plar_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic signed [plar_pkg::COORD_W-1:0] in_x_coord,
  input  logic signed [plar_pkg::COORD_W-1:0] in_y_coord,
  input  logic signed [plar_pkg::COORD_W-1:0] in_z_coord,
  input  logic        [plar_pkg::RAD_W-1:0]   in_point_radius,
  output logic                             push,
  output plar_pkg::item_t                  push_item,
  input  logic                             q_full
);

  logic            f_valid_r, f_valid_nxt;
  plar_pkg::item_t f_item_r, f_item_nxt;
  logic            load;

  assign in_stall  = f_valid_r & q_full;
  assign push      = f_valid_r & ~q_full;
  assign push_item = f_item_r;
  assign load      = in_valid & ~in_stall;

  always_comb begin
    f_valid_nxt = f_valid_r;
    f_item_nxt  = f_item_r;
    if (push) begin
      f_valid_nxt = 1'b0;
    end
    if (load) begin
      f_valid_nxt       = 1'b1;
      f_item_nxt.op     = in_kind ? plar_pkg::OP_POINT : plar_pkg::OP_BEGIN;
      f_item_nxt.x      = in_x_coord;
      f_item_nxt.y      = in_y_coord;
      f_item_nxt.z      = in_z_coord;
      f_item_nxt.radius = in_point_radius;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
    f_item_r <= f_item_nxt;
  end

endmodule

@@ sv/plar_fifo.sv @@
// ----------------------------------------------------------------------------
// plar_fifo: short word queue
// Holds decoded words between the input stage and the segment engine.
// ----------------------------------------------------------------------------
module plar_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  plar_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output plar_pkg::item_t pop_item,
  output logic            empty
);

  plar_pkg::item_t                  mem_r [plar_pkg::FIFO_DEPTH];
  logic [plar_pkg::FIFO_AW-1:0]     wp_r, rp_r;
  logic [plar_pkg::FIFO_AW:0]       cnt_r;

  assign full     = (cnt_r == (plar_pkg::FIFO_AW+1)'(plar_pkg::FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (plar_pkg::FIFO_AW+1)'(push) - (plar_pkg::FIFO_AW+1)'(pop);
    end
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

@@ sv/plar_back.sv @@
// ----------------------------------------------------------------------------
// plar_back: segment engine
// Measures each segment, resamples it along its arc length and drives the
// result register. One shared multiplier, a square-root unit and a divider.
// ----------------------------------------------------------------------------
module plar_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [plar_pkg::RAD_W-1:0]          cfg_wdata,
  input  logic                                q_empty,
  input  plar_pkg::item_t                     q_item,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [plar_pkg::COORD_W-1:0] out_sample_x,
  output logic signed [plar_pkg::COORD_W-1:0] out_sample_y,
  output logic signed [plar_pkg::COORD_W-1:0] out_sample_z,
  output logic                                out_links_previous,
  output logic                                out_dropped_excess,
  output logic                                out_last_of_run
);

  localparam int CW = plar_pkg::COORD_W;
  localparam int DW = plar_pkg::DLT_W;
  localparam int LW = plar_pkg::LEN_W;
  localparam int SW = plar_pkg::SQ_W;
  localparam int RW = plar_pkg::RAD_W;
  localparam int NW = plar_pkg::CNT_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SQ   = 9'b000000010,
    S_CHK  = 9'b000000100,
    S_SQRT = 9'b000001000,
    S_CNT  = 9'b000010000,
    S_DIVC = 9'b000100000,
    S_MUL  = 9'b001000000,
    S_DIVP = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t                 st_r, st_nxt;
  logic [RW-1:0]          spc_r, spc_nxt;
  logic signed [CW-1:0]   prev_r [3];
  logic signed [CW-1:0]   prev_nxt [3];
  logic signed [CW-1:0]   pt_r [3];
  logic signed [CW-1:0]   pt_nxt [3];
  logic signed [DW-1:0]   dlt_r [3];
  logic signed [DW-1:0]   dlt_nxt [3];
  logic signed [CW-1:0]   samp_r [3];
  logic signed [CW-1:0]   samp_nxt [3];
  logic                   have_pt_r, have_pt_nxt;
  logic                   have_smp_r, have_smp_nxt;
  logic [CW-1:0]          carry_r, carry_nxt;
  logic [RW-1:0]          rad_r, rad_nxt;
  logic [1:0]             axis_r, axis_nxt;
  logic [SW-1:0]          ssum_r, ssum_nxt;
  logic [plar_pkg::RR_W-1:0] rr_r, rr_nxt;
  logic [SW-1:0]          sq_src_r, sq_src_nxt;
  logic [LW+1:0]          sq_rem_r, sq_rem_nxt;
  logic [LW-1:0]          root_r, root_nxt;
  logic [5:0]             iter_r, iter_nxt;
  logic [LW-1:0]          div_rem_r, div_rem_nxt;
  logic [LW-1:0]          div_low_r, div_low_nxt;
  logic [LW-1:0]          div_den_r, div_den_nxt;
  logic [LW-1:0]          u_r, u_nxt;
  logic [NW-1:0]          k_r, k_nxt;
  logic [NW-1:0]          n_r, n_nxt;
  logic                   exc_r, exc_nxt;
  logic                   ov_r, ov_nxt;
  logic signed [CW-1:0]   ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;
  logic                   olink_r, olink_nxt, oexc_r, oexc_nxt, olast_r, olast_nxt;

  logic [DW-1:0]          mul_a, mul_b;
  logic [SW-1:0]          mul_p;
  logic signed [DW-1:0]   dsel;
  logic [DW-1:0]          dmag;
  logic signed [CW-1:0]   psel;
  logic [LW:0]            div_t2;
  logic                   div_ge;
  logic [LW-1:0]          div_rem_s, div_low_s;
  logic [LW+3:0]          sq_t, sq_trial;
  logic                   sq_ge;
  logic [CW-1:0]          step;
  logic                   last_k;

  assign out_valid          = ov_r;
  assign out_sample_x       = ox_r;
  assign out_sample_y       = oy_r;
  assign out_sample_z       = oz_r;
  assign out_links_previous = olink_r;
  assign out_dropped_excess = oexc_r;
  assign out_last_of_run    = olast_r;

  assign step = {((spc_r == '0) ? RW'(1) : spc_r), 1'b0};

  always_comb begin
    case (axis_r)
      2'd0:    begin dsel = dlt_r[0]; psel = prev_r[0]; end
      2'd1:    begin dsel = dlt_r[1]; psel = prev_r[1]; end
      default: begin dsel = dlt_r[2]; psel = prev_r[2]; end
    endcase
  end

  assign dmag  = dsel[DW-1] ? DW'(-dsel) : DW'(dsel);
  assign mul_a = (st_r == S_SQ && axis_r == 2'd3) ? DW'(rad_r) : dmag;
  assign mul_b = (st_r == S_MUL) ? u_r : mul_a;
  assign mul_p = mul_a * mul_b;

  assign div_t2    = {div_rem_r, div_low_r[LW-1]};
  assign div_ge    = div_t2 >= {1'b0, div_den_r};
  assign div_rem_s = div_ge ? LW'(div_t2 - {1'b0, div_den_r}) : LW'(div_t2);
  assign div_low_s = {div_low_r[LW-2:0], div_ge};

  assign sq_t      = {sq_rem_r, sq_src_r[SW-1:SW-2]};
  assign sq_trial  = {2'b00, root_r, 2'b01};
  assign sq_ge     = sq_t >= sq_trial;

  assign last_k    = (k_r + 1'b1) == n_r;
  assign q_pop     = (st_r == S_IDLE) && !q_empty;

  always_comb begin
    st_nxt       = st_r;
    spc_nxt      = cfg_we ? cfg_wdata : spc_r;
    prev_nxt     = prev_r;
    pt_nxt       = pt_r;
    dlt_nxt      = dlt_r;
    samp_nxt     = samp_r;
    have_pt_nxt  = have_pt_r;
    have_smp_nxt = have_smp_r;
    carry_nxt    = carry_r;
    rad_nxt      = rad_r;
    axis_nxt     = axis_r;
    ssum_nxt     = ssum_r;
    rr_nxt       = rr_r;
    sq_src_nxt   = sq_src_r;
    sq_rem_nxt   = sq_rem_r;
    root_nxt     = root_r;
    iter_nxt     = iter_r;
    div_rem_nxt  = div_rem_r;
    div_low_nxt  = div_low_r;
    div_den_nxt  = div_den_r;
    u_nxt        = u_r;
    k_nxt        = k_r;
    n_nxt        = n_r;
    exc_nxt      = exc_r;
    ov_nxt       = (ov_r && !out_stall) ? 1'b0 : ov_r;
    ox_nxt       = ox_r;
    oy_nxt       = oy_r;
    oz_nxt       = oz_r;
    olink_nxt    = olink_r;
    oexc_nxt     = oexc_r;
    olast_nxt    = olast_r;

    unique case (st_r)
      S_IDLE: begin
        if (q_pop) begin
          if (q_item.op == plar_pkg::OP_BEGIN) begin
            prev_nxt     = '{default: '0};
            have_pt_nxt  = 1'b0;
            carry_nxt    = '0;
            have_smp_nxt = 1'b0;
          end else if (!have_pt_r) begin
            prev_nxt    = '{q_item.x, q_item.y, q_item.z};
            have_pt_nxt = 1'b1;
          end else begin
            pt_nxt   = '{q_item.x, q_item.y, q_item.z};
            rad_nxt  = q_item.radius;
            dlt_nxt[0] = {q_item.x[CW-1], q_item.x} - {prev_r[0][CW-1], prev_r[0]};
            dlt_nxt[1] = {q_item.y[CW-1], q_item.y} - {prev_r[1][CW-1], prev_r[1]};
            dlt_nxt[2] = {q_item.z[CW-1], q_item.z} - {prev_r[2][CW-1], prev_r[2]};
            axis_nxt = 2'd0;
            ssum_nxt = '0;
            st_nxt   = S_SQ;
          end
        end
      end
      S_SQ: begin
        if (axis_r == 2'd3) begin
          rr_nxt = mul_p[plar_pkg::RR_W-1:0];
          st_nxt = S_CHK;
        end else begin
          ssum_nxt = ssum_r + mul_p;
        end
        axis_nxt = axis_r + 2'd1;
      end
      S_CHK: begin
        if ({ssum_r, 4'b0000} < (SW+4)'(rr_r)) begin
          st_nxt = S_IDLE;
        end else begin
          sq_src_nxt = ssum_r;
          sq_rem_nxt = '0;
          root_nxt   = '0;
          iter_nxt   = 6'(LW - 1);
          st_nxt     = S_SQRT;
        end
      end
      S_SQRT: begin
        sq_rem_nxt = sq_ge ? (LW+2)'(sq_t - sq_trial) : (LW+2)'(sq_t);
        root_nxt   = {root_r[LW-2:0], sq_ge};
        sq_src_nxt = {sq_src_r[SW-3:0], 2'b00};
        iter_nxt   = iter_r - 6'd1;
        if (iter_r == '0) begin
          st_nxt = S_CNT;
        end
      end
      S_CNT: begin
        if ({1'b0, carry_r} <= root_r) begin
          div_rem_nxt = '0;
          div_low_nxt = root_r - {1'b0, carry_r};
          div_den_nxt = {1'b0, step};
          iter_nxt    = 6'(LW - 1);
          st_nxt      = S_DIVC;
        end else begin
          carry_nxt = carry_r - root_r[CW-1:0];
          prev_nxt  = pt_r;
          st_nxt    = S_IDLE;
        end
      end
      S_DIVC: begin
        div_rem_nxt = div_rem_s;
        div_low_nxt = div_low_s;
        iter_nxt    = iter_r - 6'd1;
        if (iter_r == '0) begin
          if (div_low_s >= LW'(plar_pkg::MAX_PER_SEGMENT - 1)) begin
            n_nxt = NW'(plar_pkg::MAX_PER_SEGMENT);
          end else begin
            n_nxt = NW'(div_low_s) + 1'b1;
          end
          exc_nxt   = div_low_s >= LW'(plar_pkg::MAX_PER_SEGMENT);
          carry_nxt = step - div_rem_s[CW-1:0];
          u_nxt     = {1'b0, carry_r};
          k_nxt     = '0;
          axis_nxt  = 2'd0;
          if (root_r == '0) begin
            samp_nxt = prev_r;
            st_nxt   = S_OUT;
          end else begin
            st_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        div_rem_nxt = mul_p[SW-1:LW];
        div_low_nxt = mul_p[LW-1:0];
        div_den_nxt = root_r;
        iter_nxt    = 6'(LW - 1);
        st_nxt      = S_DIVP;
      end
      S_DIVP: begin
        div_rem_nxt = div_rem_s;
        div_low_nxt = div_low_s;
        iter_nxt    = iter_r - 6'd1;
        if (iter_r == '0) begin
          if (dsel[DW-1]) begin
            samp_nxt[axis_r] = psel - $signed(div_low_s[CW-1:0]);
          end else begin
            samp_nxt[axis_r] = psel + $signed(div_low_s[CW-1:0]);
          end
          if (axis_r == 2'd2) begin
            axis_nxt = 2'd0;
            st_nxt   = S_OUT;
          end else begin
            axis_nxt = axis_r + 2'd1;
            st_nxt   = S_MUL;
          end
        end
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt       = 1'b1;
          ox_nxt       = samp_r[0];
          oy_nxt       = samp_r[1];
          oz_nxt       = samp_r[2];
          olink_nxt    = have_smp_r;
          olast_nxt    = last_k;
          oexc_nxt     = last_k & exc_r;
          have_smp_nxt = 1'b1;
          k_nxt        = k_r + 1'b1;
          u_nxt        = u_r + LW'(step);
          if (last_k) begin
            prev_nxt = pt_r;
            st_nxt   = S_IDLE;
          end else begin
            st_nxt = S_MUL;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      spc_r      <= plar_pkg::SPACING_RESET;
      prev_r     <= '{default: '0};
      have_pt_r  <= 1'b0;
      have_smp_r <= 1'b0;
      carry_r    <= '0;
      ov_r       <= 1'b0;
      k_r        <= '0;
    end else begin
      st_r       <= st_nxt;
      spc_r      <= spc_nxt;
      prev_r     <= prev_nxt;
      have_pt_r  <= have_pt_nxt;
      have_smp_r <= have_smp_nxt;
      carry_r    <= carry_nxt;
      ov_r       <= ov_nxt;
      k_r        <= k_nxt;
    end
    pt_r      <= pt_nxt;
    dlt_r     <= dlt_nxt;
    samp_r    <= samp_nxt;
    rad_r     <= rad_nxt;
    axis_r    <= axis_nxt;
    ssum_r    <= ssum_nxt;
    rr_r      <= rr_nxt;
    sq_src_r  <= sq_src_nxt;
    sq_rem_r  <= sq_rem_nxt;
    root_r    <= root_nxt;
    iter_r    <= iter_nxt;
    div_rem_r <= div_rem_nxt;
    div_low_r <= div_low_nxt;
    div_den_r <= div_den_nxt;
    u_r       <= u_nxt;
    n_r       <= n_nxt;
    exc_r     <= exc_nxt;
    ox_r      <= ox_nxt;
    oy_r      <= oy_nxt;
    oz_r      <= oz_nxt;
    olink_r   <= olink_nxt;
    oexc_r    <= oexc_nxt;
    olast_r   <= olast_nxt;
  end

`ifndef NO_ASSERTIONS
  a_div_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIVC || st_r == S_DIVP) |-> (div_rem_r < div_den_r))
    else $error("divider remainder not below divisor");

  a_sqrt_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SQRT) |-> (sq_rem_r <= {1'b0, root_r, 1'b0}))
    else $error("square-root remainder exceeds twice the root");

  a_sample_limit: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= NW'(plar_pkg::MAX_PER_SEGMENT))
    else $error("more samples than the per-segment limit");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT && (!ov_r || !out_stall) && last_k) |=> (st_r == S_IDLE && olast_r))
    else $error("final sample did not end the run");
`endif

endmodule

@@ sv/polyline_arc_length_resampler_top.sv @@
// Point word: the segment is measured first, then each sample takes a multiply and a divide per axis.
// Begin-path and first-point words retire straight from idle; rejected points after the radius check.
// The square-root and divider loops run 33 steps each; the divider serves both count and position.
// Up to five words queue ahead of the engine while it works.
// Synchronous active-low reset clears the path state and sets spacing to 1.0.
// ----------------------------------------------------------------------------
// polyline_arc_length_resampler_top: 3D polyline resampler
// Turns a stream of stroke points into samples evenly spaced in arc length.
// ----------------------------------------------------------------------------
module polyline_arc_length_resampler_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [plar_pkg::RAD_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic signed [plar_pkg::COORD_W-1:0] in_x_coord,
  input  logic signed [plar_pkg::COORD_W-1:0] in_y_coord,
  input  logic signed [plar_pkg::COORD_W-1:0] in_z_coord,
  input  logic        [plar_pkg::RAD_W-1:0]   in_point_radius,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [plar_pkg::COORD_W-1:0] out_sample_x,
  output logic signed [plar_pkg::COORD_W-1:0] out_sample_y,
  output logic signed [plar_pkg::COORD_W-1:0] out_sample_z,
  output logic                                out_links_previous,
  output logic                                out_dropped_excess,
  output logic                                out_last_of_run
);

  logic            push, q_full, q_pop, q_empty;
  plar_pkg::item_t push_item, q_item;

  plar_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_x_coord, .in_y_coord,
    .in_z_coord, .in_point_radius, .push, .push_item, .q_full
  );

  plar_fifo u_fifo (
    .clk, .rst_n, .push, .push_item, .full(q_full), .pop(q_pop),
    .pop_item(q_item), .empty(q_empty)
  );

  plar_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .q_empty, .q_item, .q_pop,
    .out_valid, .out_stall, .out_sample_x, .out_sample_y, .out_sample_z,
    .out_links_previous, .out_dropped_excess, .out_last_of_run
  );

endmodule
